@@ rtl/bsa_pkg.sv @@
package bsa_pkg;

   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 16;
   localparam int COUNT_W    = 13;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_BINS   = 2;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_BIN0_SIZE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BIN0_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIN0_BASE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BIN1_SIZE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BIN1_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BIN1_BASE  = 3'd5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;
   localparam logic [7:0]         BYTE_FULL = 8'hFF;

endpackage

@@ rtl/bsa_div.sv @@
module bsa_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        run_ff;
   logic [4:0]  step_ff;
   logic [15:0] rem_ff;
   logic [31:0] quo_ff;
   logic        done_ff;
   logic [16:0] trial;
   logic [16:0] diff;
   logic        ge;

   always_comb begin
      trial = {rem_ff, quo_ff[31]};
      diff  = trial - {1'b0, divisor};
      ge    = (trial >= {1'b0, divisor});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (run_ff) begin
         rem_ff <= ge ? diff[15:0] : trial[15:0];
         quo_ff <= {quo_ff[30:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/bitmap_slot_allocator.sv @@
// Fixed-size slot allocator with up to two bins of bitmap-tracked slots.
// The request channel (req_) carries one item: an allocate of req_alloc_size
// bytes or a free of req_free_address. The result channel (rsp_) returns one
// item per request with a status, the slot address, the bin and its count.
// Bins are set up through the csr_ write port; the user must do so only while
// the block is idle, which the block itself does not enforce. One item is
// worked on at a time; req_stall is high until it is finished. An allocate
// that hits a hint goes from S_POP via S_HRD and S_HCHK to S_SET; a bitmap
// scan reads and checks one byte at a time, each one registered memory read.
// A free tests each bin range in turn, then has the bit-serial divider turn
// the offset into a slot. One shared multiplier forms range ends and slot
// addresses. After reset the bitmap memory, NUM_BINS * SLOTS_PER_BIN / 8
// bytes (1024 by default), is cleared one byte per cycle; requests stall
// during that pass while configuration writes are taken as usual.
// A finished item waits in the output register while rsp_stall is high; a
// new request is still accepted meanwhile, and its result is held back until
// the output register is free.
module bitmap_slot_allocator #(
   parameter int NUM_BINS      = 2,
   parameter int SLOTS_PER_BIN = 4096,
   parameter int HINT_ENTRIES  = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [bsa_pkg::SIZE_W-1:0]        req_alloc_size,
   input  logic [bsa_pkg::ADDR_W-1:0]        req_free_address,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bsa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bsa_pkg::ADDR_W-1:0]        rsp_slot_address,
   output logic                              rsp_bin_index,
   output logic [bsa_pkg::COUNT_W-1:0]       rsp_used_count,
   input  logic                              csr_write_enable,
   input  logic [bsa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bsa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bsa_pkg::*;

   localparam int SLOT_W    = $clog2(SLOTS_PER_BIN);
   localparam int BYTE_W    = SLOT_W - 3;
   localparam int BYTES     = SLOTS_PER_BIN / 8;
   localparam int MAP_DEPTH = NUM_BINS * BYTES;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int EFF_W     = $clog2(SLOTS_PER_BIN + 1);
   localparam int CAP_W     = (EFF_W > COUNT_W) ? EFF_W : COUNT_W;
   localparam int PROD_W    = EFF_W + SIZE_W;
   localparam int END_W     = ((PROD_W > ADDR_W) ? PROD_W : ADDR_W) + 1;
   localparam int HI_W      = (HINT_ENTRIES > 1) ? $clog2(HINT_ENTRIES) : 1;
   localparam int HDEPTH    = NUM_BINS * HINT_ENTRIES;
   localparam int HA_W      = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;

   typedef enum logic [18:0] {
      S_CLEAR = 19'b0000000000000000001,
      S_IDLE  = 19'b0000000000000000010,
      S_MATCH = 19'b0000000000000000100,
      S_FMUL  = 19'b0000000000000001000,
      S_FCHK  = 19'b0000000000000010000,
      S_FDIV  = 19'b0000000000000100000,
      S_FRD   = 19'b0000000000001000000,
      S_FUPD  = 19'b0000000000010000000,
      S_POP   = 19'b0000000000100000000,
      S_HRD   = 19'b0000000001000000000,
      S_HCHK  = 19'b0000000010000000000,
      S_SRD   = 19'b0000000100000000000,
      S_SCHK  = 19'b0000001000000000000,
      S_SET   = 19'b0000010000000000000,
      S_NCHK  = 19'b0000100000000000000,
      S_AMUL  = 19'b0001000000000000000,
      S_AADD  = 19'b0010000000000000000,
      S_DONE  = 19'b0100000000000000000,
      S_SPARE = 19'b1000000000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0]  size_cfg_ff [REG_BINS];
   logic [COUNT_W-1:0] count_cfg_ff [REG_BINS];
   logic [ADDR_W-1:0]  base_cfg_ff [REG_BINS];

   logic                func_ff, func_in;
   logic [SIZE_W-1:0]   size_req_ff, size_req_in;
   logic [ADDR_W-1:0]   addr_req_ff, addr_req_in;
   logic                bin_ff, bin_in;
   logic                cb_ff, cb_in;
   logic [BYTE_W-1:0]   pos_ff, pos_in;
   logic [2:0]          bit_ff, bit_in;
   logic [7:0]          byte_ff, byte_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [COUNT_W-1:0]  res_count_ff, res_count_in;
   logic [COUNT_W-1:0]  cnt_ff [NUM_BINS];
   logic [COUNT_W-1:0]  cnt_in [NUM_BINS];
   logic [NUM_BINS-1:0][HINT_ENTRIES-1:0] hv_ff, hv_in;
   logic [MAP_AW-1:0]   clr_ff, clr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic                rsp_bin_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_load;

   logic [7:0]          map_mem [MAP_DEPTH];
   logic [7:0]          map_q_ff;
   logic                map_we;
   logic [MAP_AW-1:0]   map_wa;
   logic [MAP_AW-1:0]   map_ra;
   logic [7:0]          map_wd;

   logic [BYTE_W-1:0]   hint_mem [HDEPTH];
   logic [BYTE_W-1:0]   hint_q_ff;
   logic                hint_we;
   logic [HA_W-1:0]     hint_wa;
   logic [HA_W-1:0]     hint_ra;
   logic [BYTE_W-1:0]   hint_wd;

   logic [EFF_W-1:0]    eff [NUM_BINS];
   logic [CAP_W-1:0]    cap [NUM_BINS];
   logic [31:0]         nb [NUM_BINS];

   logic                amatch;
   logic                abin;
   logic                pop_hit;
   logic [HI_W-1:0]     pop_idx;
   logic                free_hit;
   logic [HI_W-1:0]     free_idx;
   logic                push_en;
   logic [BYTE_W-1:0]   push_pos;
   logic [2:0]          zero_bit;
   logic [7:0]          set_byte;
   logic [BYTE_W-1:0]   pos_inc;
   logic                pos_inc_ok;
   logic [EFF_W-1:0]    mul_a;
   logic [SIZE_W-1:0]   mul_b;
   logic [END_W-1:0]    range_end;
   logic                in_range;
   logic                div_start;
   logic                div_done;
   logic [31:0]         div_q;
   logic [COUNT_W-1:0]  cnt_cur;

   function automatic logic [MAP_AW-1:0] map_addr(input logic b, input logic [BYTE_W-1:0] p);
      return MAP_AW'(b ? BYTES : 0) + MAP_AW'(p);
   endfunction

   function automatic logic [HA_W-1:0] hint_addr(input logic b, input logic [HI_W-1:0] i);
      return HA_W'(b ? HINT_ENTRIES : 0) + HA_W'(i);
   endfunction

   bsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (addr_req_ff - base_cfg_ff[cb_ff]),
      .divisor  (size_cfg_ff[cb_ff]),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      for (int b = 0; b < NUM_BINS; b++) begin
         cap[b] = CAP_W'(count_cfg_ff[b]);
         if (cap[b] > CAP_W'(SLOTS_PER_BIN)) begin
            cap[b] = CAP_W'(SLOTS_PER_BIN);
         end
         cap[b][4:0] = 5'd0;
         eff[b] = EFF_W'(cap[b]);
         nb[b]  = 32'(eff[b] >> 3);
      end
   end

   always_comb begin
      amatch = 1'b0;
      abin   = 1'b0;
      for (int b = NUM_BINS - 1; b >= 0; b--) begin
         if (nb[b] != 32'd0 && size_cfg_ff[b] == size_req_ff) begin
            amatch = 1'b1;
            abin   = 1'(b);
         end
      end
      pop_hit  = 1'b0;
      pop_idx  = '0;
      free_hit = 1'b0;
      free_idx = '0;
      for (int i = HINT_ENTRIES - 1; i >= 0; i--) begin
         if (hv_ff[bin_ff][i]) begin
            pop_hit = 1'b1;
            pop_idx = HI_W'(i);
         end else begin
            free_hit = 1'b1;
            free_idx = HI_W'(i);
         end
      end
      zero_bit = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (!byte_ff[i]) begin
            zero_bit = 3'(i);
         end
      end
      set_byte   = byte_ff | (8'd1 << zero_bit);
      pos_inc    = pos_ff + BYTE_W'(1);
      pos_inc_ok = (32'(pos_ff) + 32'd1) < nb[bin_ff];
      cnt_cur    = cnt_ff[bin_ff];
      range_end  = END_W'(base_cfg_ff[cb_ff]) + END_W'(prod_ff);
      in_range   = (nb[cb_ff] != 32'd0) && (size_cfg_ff[cb_ff] != '0) &&
                   (addr_req_ff >= base_cfg_ff[cb_ff]) &&
                   (END_W'(addr_req_ff) < range_end);
      if (func_ff == FUNC_FREE) begin
         mul_a = eff[cb_ff];
         mul_b = size_cfg_ff[cb_ff];
      end else begin
         mul_a = EFF_W'({pos_ff, bit_ff});
         mul_b = size_cfg_ff[bin_ff];
      end
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      size_req_in   = size_req_ff;
      addr_req_in   = addr_req_ff;
      bin_in        = bin_ff;
      cb_in         = cb_ff;
      pos_in        = pos_ff;
      bit_in        = bit_ff;
      byte_in       = byte_ff;
      prod_in       = prod_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_count_in  = res_count_ff;
      cnt_in        = cnt_ff;
      hv_in         = hv_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_load      = 1'b0;
      map_we        = 1'b0;
      map_wa        = map_addr(bin_ff, pos_ff);
      map_wd        = set_byte;
      map_ra        = map_addr(bin_ff, pos_ff);
      hint_ra       = hint_addr(bin_ff, pop_idx);
      push_en       = 1'b0;
      push_pos      = pos_ff;
      div_start     = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            map_we = 1'b1;
            map_wa = clr_ff;
            map_wd = 8'd0;
            clr_in = clr_ff + MAP_AW'(1);
            if (clr_ff == MAP_AW'(MAP_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in     = req_func;
               size_req_in = req_alloc_size;
               addr_req_in = req_free_address;
               state_in    = S_MATCH;
            end
         end
         S_MATCH: begin
            res_status_in = STATUS_NO_MATCH;
            res_addr_in   = '0;
            res_count_in  = '0;
            cb_in         = 1'b0;
            if (func_ff == FUNC_FREE) begin
               state_in = S_FMUL;
            end else if (amatch) begin
               bin_in   = abin;
               state_in = S_POP;
            end else begin
               bin_in   = 1'b0;
               state_in = S_DONE;
            end
         end
         S_FMUL: begin
            prod_in  = mul_a * mul_b;
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (in_range) begin
               bin_in    = cb_ff;
               div_start = 1'b1;
               state_in  = S_FDIV;
            end else if (32'(cb_ff) == NUM_BINS - 1) begin
               bin_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               cb_in    = 1'b1;
               state_in = S_FMUL;
            end
         end
         S_FDIV: begin
            if (div_done) begin
               pos_in   = div_q[SLOT_W-1:3];
               bit_in   = div_q[2:0];
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            state_in = S_FUPD;
         end
         S_FUPD: begin
            map_wd       = map_q_ff & ~(8'd1 << bit_ff);
            res_count_in = cnt_cur;
            if (map_q_ff[bit_ff]) begin
               map_we = 1'b1;
               if (cnt_cur != '0) begin
                  cnt_in[bin_ff] = cnt_cur - COUNT_W'(1);
                  res_count_in   = cnt_cur - COUNT_W'(1);
               end
            end
            push_en       = 1'b1;
            res_status_in = STATUS_DONE;
            state_in      = S_DONE;
         end
         S_POP: begin
            pos_in = '0;
            if (pop_hit) begin
               hv_in[bin_ff][pop_idx] = 1'b0;
               state_in = S_HRD;
            end else begin
               state_in = S_SRD;
            end
         end
         S_HRD: begin
            pos_in   = hint_q_ff;
            map_ra   = map_addr(bin_ff, hint_q_ff);
            state_in = S_HCHK;
         end
         S_HCHK: begin
            if (32'(pos_ff) < nb[bin_ff] && map_q_ff != BYTE_FULL) begin
               byte_in  = map_q_ff;
               state_in = S_SET;
            end else begin
               pos_in   = '0;
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            state_in = S_SCHK;
         end
         S_SCHK: begin
            if (map_q_ff != BYTE_FULL) begin
               byte_in  = map_q_ff;
               state_in = S_SET;
            end else if (pos_inc_ok) begin
               pos_in   = pos_inc;
               state_in = S_SRD;
            end else begin
               res_status_in = STATUS_FULL;
               res_count_in  = cnt_cur;
               state_in      = S_DONE;
            end
         end
         S_SET: begin
            map_we = 1'b1;
            bit_in = zero_bit;
            map_ra = map_addr(bin_ff, pos_inc);
            if (cnt_cur != COUNT_MAX) begin
               cnt_in[bin_ff] = cnt_cur + COUNT_W'(1);
               res_count_in   = cnt_cur + COUNT_W'(1);
            end else begin
               res_count_in = cnt_cur;
            end
            if (set_byte != BYTE_FULL) begin
               push_en  = 1'b1;
               state_in = S_AMUL;
            end else if (pos_inc_ok) begin
               state_in = S_NCHK;
            end else begin
               state_in = S_AMUL;
            end
         end
         S_NCHK: begin
            push_pos = pos_inc;
            push_en  = (map_q_ff != BYTE_FULL);
            state_in = S_AMUL;
         end
         S_AMUL: begin
            prod_in  = mul_a * mul_b;
            state_in = S_AADD;
         end
         S_AADD: begin
            res_status_in = STATUS_DONE;
            res_addr_in   = base_cfg_ff[bin_ff] + ADDR_W'(prod_ff);
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (push_en && free_hit) begin
         hv_in[bin_ff][free_idx] = 1'b1;
      end
   end

   assign hint_we   = push_en && free_hit;
   assign hint_wa   = hint_addr(bin_ff, free_idx);
   assign hint_wd   = push_pos;
   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      map_q_ff <= map_mem[map_ra];
      if (hint_we) begin
         hint_mem[hint_wa] <= hint_wd;
      end
      hint_q_ff <= hint_mem[hint_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         hv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BINS; b++) begin
            cnt_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hv_ff        <= hv_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      size_req_ff   <= size_req_in;
      addr_req_ff   <= addr_req_in;
      bin_ff        <= bin_in;
      cb_ff         <= cb_in;
      pos_ff        <= pos_in;
      bit_ff        <= bit_in;
      byte_ff       <= byte_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_count_ff  <= res_count_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_bin_ff    <= bin_ff;
         rsp_count_ff  <= res_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < REG_BINS; b++) begin
            size_cfg_ff[b]  <= SIZE_W'(1);
            count_cfg_ff[b] <= '0;
            base_cfg_ff[b]  <= '0;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_BIN0_SIZE:  size_cfg_ff[0]  <= csr_wdata[SIZE_W-1:0];
            REG_BIN0_COUNT: count_cfg_ff[0] <= csr_wdata[COUNT_W-1:0];
            REG_BIN0_BASE:  base_cfg_ff[0]  <= csr_wdata[ADDR_W-1:0];
            REG_BIN1_SIZE:  size_cfg_ff[1]  <= csr_wdata[SIZE_W-1:0];
            REG_BIN1_COUNT: count_cfg_ff[1] <= csr_wdata[COUNT_W-1:0];
            REG_BIN1_BASE:  base_cfg_ff[1]  <= csr_wdata[ADDR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_address = rsp_addr_ff;
   assign rsp_bin_index    = rsp_bin_ff;
   assign rsp_used_count   = rsp_count_ff;

endmodule

@@ rtl/bsa_checker.sv @@
module bsa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [bsa_pkg::STATUS_W-1:0]   rsp_status,
   input logic [bsa_pkg::ADDR_W-1:0]     rsp_slot_address,
   input logic                           rsp_bin_index,
   input logic [bsa_pkg::COUNT_W-1:0]    rsp_used_count
);
   import bsa_pkg::*;

   // An accepted item keeps the request side busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted twice in a row");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_DONE || rsp_status == STATUS_NO_MATCH ||
                     rsp_status == STATUS_FULL))
      else $error("unknown status");

   a_address_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_DONE |-> rsp_slot_address == '0)
      else $error("address given on failed item");

   a_no_match_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NO_MATCH |-> !rsp_bin_index && rsp_used_count == '0)
      else $error("bin or count given without a matching bin");

   a_stalled_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot_address))
      else $error("stalled result changed");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);

@@ dv/bitmap_slot_allocator_tb.sv @@
`timescale 1ns / 1ps

module bitmap_slot_allocator_tb;
   import bsa_pkg::*;

   localparam int NBINS = 2;
   localparam int SLOTS = 4096;
   localparam int HINTS = 8;
   localparam int BYTES = SLOTS / 8;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   slot_address;
      logic                bin_index;
      logic [COUNT_W-1:0]  used_count;
   } slot_result_type;

   class alloc_scoreboard;
      logic [7:0]          bitmap [NBINS][BYTES];
      logic [9:0]          hint_pos [NBINS][HINTS];
      bit                  hint_ok [NBINS][HINTS];
      logic [COUNT_W-1:0]  used [NBINS];
      logic [SIZE_W-1:0]   elem_size [NBINS];
      logic [COUNT_W-1:0]  elem_count [NBINS];
      logic [ADDR_W-1:0]   base [NBINS];
      slot_result_type     pending [$];
      int                  errors;

      function new();
         for (int b = 0; b < NBINS; b++) begin
            for (int i = 0; i < BYTES; i++) bitmap[b][i] = 8'h00;
            for (int i = 0; i < HINTS; i++) begin
               hint_ok[b][i] = 0;
               hint_pos[b][i] = '0;
            end
            used[b] = '0;
            elem_size[b] = SIZE_W'(1);
            elem_count[b] = '0;
            base[b] = '0;
         end
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         int b;
         b = idx / 3;
         case (idx)
            REG_BIN0_SIZE, REG_BIN1_SIZE: elem_size[b] = v[SIZE_W-1:0];
            REG_BIN0_COUNT, REG_BIN1_COUNT: elem_count[b] = v[COUNT_W-1:0];
            REG_BIN0_BASE, REG_BIN1_BASE: base[b] = v;
            default: ;
         endcase
      endfunction

      function int bytes_of(int b);
         int c;
         c = elem_count[b];
         if (c > SLOTS) c = SLOTS;
         c = c - c % 32;
         return c / 8;
      endfunction

      function void push_hint(int b, int p);
         for (int i = 0; i < HINTS; i++)
            if (!hint_ok[b][i]) begin
               hint_ok[b][i] = 1;
               hint_pos[b][i] = 10'(p);
               return;
            end
      endfunction

      function slot_result_type allocate(logic [SIZE_W-1:0] size);
         slot_result_type r;
         int nb, p, j;
         bit found, popped;
         logic [31:0] slot;
         r = '{status: STATUS_NO_MATCH, slot_address: '0, bin_index: 0, used_count: '0};
         for (int b = 0; b < NBINS; b++) begin
            nb = bytes_of(b);
            if (nb == 0 || elem_size[b] != size) continue;
            r.bin_index = 1'(b);
            found = 0;
            popped = 0;
            for (int i = 0; i < HINTS && !popped; i++)
               if (hint_ok[b][i]) begin
                  hint_ok[b][i] = 0;
                  p = hint_pos[b][i];
                  popped = 1;
               end
            if (popped && p < nb && bitmap[b][p] != BYTE_FULL) found = 1;
            if (!found)
               for (p = 0; p < nb; p++)
                  if (bitmap[b][p] != BYTE_FULL) begin
                     found = 1;
                     break;
                  end
            if (!found) begin
               r.status = STATUS_FULL;
               r.used_count = used[b];
               return r;
            end
            for (j = 0; j < 8; j++)
               if (!bitmap[b][p][j]) break;
            bitmap[b][p][j] = 1'b1;
            if (bitmap[b][p] != BYTE_FULL) push_hint(b, p);
            else if (p + 1 < nb && bitmap[b][p+1] != BYTE_FULL) push_hint(b, p + 1);
            if (used[b] != COUNT_MAX) used[b]++;
            slot = 32'(p * 8 + j);
            r.status = STATUS_DONE;
            r.slot_address = base[b] + slot * size;
            r.used_count = used[b];
            return r;
         end
         return r;
      endfunction

      function slot_result_type release_slot(logic [ADDR_W-1:0] addr);
         slot_result_type r;
         int nb, p, bit_n;
         longint unsigned range_end, slot;
         r = '{status: STATUS_NO_MATCH, slot_address: '0, bin_index: 0, used_count: '0};
         for (int b = 0; b < NBINS; b++) begin
            nb = bytes_of(b);
            if (nb == 0 || elem_size[b] == 0) continue;
            range_end = longint'(base[b]) + longint'(elem_size[b]) * (nb * 8);
            if (addr < base[b] || longint'(addr) >= range_end) continue;
            slot = (addr - base[b]) / elem_size[b];
            p = int'(slot / 8);
            bit_n = int'(slot % 8);
            if (p >= nb) continue;
            if (bitmap[b][p][bit_n]) begin
               bitmap[b][p][bit_n] = 1'b0;
               if (used[b] != 0) used[b]--;
            end
            push_hint(b, p);
            r.status = STATUS_DONE;
            r.bin_index = 1'(b);
            r.used_count = used[b];
            return r;
         end
         return r;
      endfunction

      function void note_request(logic fn, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a);
         pending.push_back(fn == FUNC_ALLOC ? allocate(sz) : release_slot(a));
      endfunction

      task check_result(slot_result_type got);
         slot_result_type w;
         if (pending.size() == 0) begin
            report_mismatch("result item with nothing expected");
            return;
         end
         w = pending.pop_front();
         if (got.status !== w.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, w.status));
         if (got.slot_address !== w.slot_address)
            report_mismatch($sformatf("slot_address %h, expected %h",
                                      got.slot_address, w.slot_address));
         if (got.bin_index !== w.bin_index)
            report_mismatch($sformatf("bin_index %0d, expected %0d",
                                      got.bin_index, w.bin_index));
         if (got.used_count !== w.used_count)
            report_mismatch($sformatf("used_count %0d, expected %0d",
                                      got.used_count, w.used_count));
      endtask

      task report_mismatch(string msg);
         errors++;
         if (errors <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_stall;
   logic                  req_func = 0;
   logic [SIZE_W-1:0]     req_alloc_size = 0;
   logic [ADDR_W-1:0]     req_free_address = 0;
   logic                  rsp_valid;
   logic                  rsp_stall = 0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ADDR_W-1:0]     rsp_slot_address;
   logic                  rsp_bin_index;
   logic [COUNT_W-1:0]    rsp_used_count;
   logic                  csr_write_enable = 0;
   logic [CSR_IDX_W-1:0]  csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_wdata = 0;

   alloc_scoreboard sb = new();
   bit calm = 0;

   bitmap_slot_allocator u_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result('{rsp_status, rsp_slot_address, rsp_bin_index, rsp_used_count});
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 31);
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   task automatic send(logic fn, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a);
      do @(posedge clock); while (!calm && $urandom_range(99) < 31);
      req_valid <= 1;
      req_func <= fn;
      req_alloc_size <= sz;
      req_free_address <= a;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(fn, sz, a);
      req_valid <= 0;
   endtask

   task automatic settle();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic setup(logic [15:0] s0, logic [12:0] c0, logic [31:0] b0,
                        logic [15:0] s1, logic [12:0] c1, logic [31:0] b1);
      settle();
      write_reg(REG_BIN0_SIZE, 32'(s0));
      write_reg(REG_BIN0_COUNT, 32'(c0));
      write_reg(REG_BIN0_BASE, b0);
      write_reg(REG_BIN1_SIZE, 32'(s1));
      write_reg(REG_BIN1_COUNT, 32'(c1));
      write_reg(REG_BIN1_BASE, b1);
      csr_write_enable <= 0;
   endtask

   task automatic random_phase(int n);
      logic [SIZE_W-1:0] s;
      logic [ADDR_W-1:0] a;
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 50) begin
            s = ($urandom_range(9) == 0) ? 16'($urandom)
                : ($urandom_range(1) ? sb.elem_size[0] : sb.elem_size[1]);
            send(FUNC_ALLOC, s, $urandom);
         end else if (k < 85) begin
            b_pick(a);
            send(FUNC_FREE, 16'($urandom), a);
         end else begin
            send(FUNC_FREE, 16'($urandom), $urandom);
         end
      end
   endtask

   task automatic b_pick(output logic [ADDR_W-1:0] a);
      int b;
      b = $urandom_range(1);
      a = sb.base[b] + sb.elem_size[b] * $urandom_range(SLOTS + 40)
          + ($urandom_range(7) == 0 ? $urandom_range(3) : 0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      setup(16'd8, 13'd64, 32'h1000, 16'd16, 13'd40, 32'h8000);
      calm = 1;
      for (int i = 0; i < 10; i++) send(FUNC_ALLOC, 16'd16, 0);
      send(FUNC_ALLOC, 16'd16, 0);
      send(FUNC_ALLOC, 16'd16, 0);
      for (int i = 0; i < 3; i++) send(FUNC_ALLOC, 16'd8, 0);
      send(FUNC_ALLOC, 16'd3, 0);
      send(FUNC_FREE, 0, 32'h8010);
      send(FUNC_FREE, 0, 32'h8010);
      send(FUNC_FREE, 0, 32'h8000 + 16 * 32);
      send(FUNC_FREE, 0, 32'h0FFF);
      send(FUNC_FREE, 0, 32'h1008);
      send(FUNC_FREE, 0, 32'hFFFF_FFFF);
      send(FUNC_ALLOC, 16'hFFFF, 0);
      send(FUNC_ALLOC, 16'd0, 0);
      calm = 0;
      setup(16'd0, 13'd32, 32'h5, 16'hFFFF, 13'd4096, 32'hFFFF_0000);
      send(FUNC_ALLOC, 16'd0, 0);
      send(FUNC_FREE, 0, 32'h5);
      send(FUNC_ALLOC, 16'hFFFF, 0);
      send(FUNC_ALLOC, 16'hFFFF, 0);
      send(FUNC_FREE, 0, 32'hFFFF_0000 + 16'hFFFF);
      random_phase(80);
      setup(16'd4, 13'd33, 32'h0, 16'd4, 13'd8191, 32'hFFFF_FFF0);
      calm = 1;
      random_phase(120);
      calm = 0;
      setup(16'd2, 13'd32, 32'h100, 16'd1, 13'd64, 32'h200);
      random_phase(250);
      setup(16'h1234, 13'd96, $urandom, 16'd7, 13'd0, 32'h0);
      random_phase(150);
      setup(16'd1, 13'd32, 32'h0, 16'd1, 13'd32, 32'h40);
      random_phase(150);
      settle();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #50ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule
